@@ sv/msc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg
// Shared opcodes, event codes and the burst descriptor for the command parser.
// ----------------------------------------------------------------------------
package msc_pkg;

    // status opcodes (channel opcodes compared with the low nibble cleared)
    localparam logic [7:0] OP_ANALOG         = 8'hE0;
    localparam logic [7:0] OP_DIGITAL        = 8'h90;
    localparam logic [7:0] OP_REPORT_ANALOG  = 8'hC0;
    localparam logic [7:0] OP_REPORT_DIGITAL = 8'hD0;
    localparam logic [7:0] OP_PIN_MODE       = 8'hF4;
    localparam logic [7:0] OP_PIN_VALUE      = 8'hF5;
    localparam logic [7:0] OP_SYSEX_START    = 8'hF0;
    localparam logic [7:0] OP_SYSEX_END      = 8'hF7;
    localparam logic [7:0] OP_VERSION        = 8'hF9;
    localparam logic [7:0] OP_RESET          = 8'hFF;
    localparam logic [7:0] FIRMWARE_QUERY    = 8'h79;

    // event codes on the output
    localparam logic [2:0] EV_ANALOG         = 3'd0;
    localparam logic [2:0] EV_DIGITAL        = 3'd1;
    localparam logic [2:0] EV_PIN_MODE       = 3'd2;
    localparam logic [2:0] EV_PIN_VALUE      = 3'd3;
    localparam logic [2:0] EV_REPORT_ANALOG  = 3'd4;
    localparam logic [2:0] EV_REPORT_DIGITAL = 3'd5;

    // pending command codes: none, otherwise event code plus one
    localparam logic [2:0] PC_NONE           = 3'd0;
    localparam logic [2:0] PC_ANALOG         = 3'd1;
    localparam logic [2:0] PC_DIGITAL        = 3'd2;
    localparam logic [2:0] PC_PIN_MODE       = 3'd3;
    localparam logic [2:0] PC_PIN_VALUE      = 3'd4;
    localparam logic [2:0] PC_REPORT_ANALOG  = 3'd5;
    localparam logic [2:0] PC_REPORT_DIGITAL = 3'd6;

    localparam int unsigned MAX_BEATS = 5;

    typedef logic [MAX_BEATS-1:0][7:0] t_tx_bytes;

    typedef struct packed {
        logic [6:0] fw_major;
        logic [6:0] fw_minor;
        logic [6:0] pr_major;
        logic [6:0] pr_minor;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  count;       // beats in the burst, 0 when none
        logic        is_tx;
        logic [2:0]  event_code;
        logic [6:0]  channel;
        logic [13:0] value;
        t_tx_bytes   tx;
    } t_burst;

    typedef struct packed {
        logic free;               // burst register can take a new burst
    } t_seq_status;

endpackage

@@ sv/msc_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_parser
// Parser state and single-pass decode of one received byte into a burst.
// ----------------------------------------------------------------------------
module msc_parser #(
    parameter int unsigned BUFFER_BYTES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_rx_byte,
    input  msc_pkg::t_cfg   i_cfg,
    output msc_pkg::t_burst o_burst
);
    import msc_pkg::*;

    localparam logic [6:0] BUF_LIMIT = 7'(BUFFER_BYTES);

    logic       r_in_sysex,      n_in_sysex;
    logic [6:0] r_sysex_count,   n_sysex_count;
    logic [1:0] r_bytes_pending, n_bytes_pending;
    logic [2:0] r_pending_cmd,   n_pending_cmd;
    logic [3:0] r_channel_latch, n_channel_latch;
    logic [7:0] r_data0,         n_data0;
    logic [7:0] r_data1,         n_data1;

    logic [7:0] w_op;
    t_burst     w_burst;

    always_comb begin
        n_in_sysex      = r_in_sysex;
        n_sysex_count   = r_sysex_count;
        n_bytes_pending = r_bytes_pending;
        n_pending_cmd   = r_pending_cmd;
        n_channel_latch = r_channel_latch;
        n_data0         = r_data0;
        n_data1         = r_data1;
        w_burst         = '0;
        w_op            = i_rx_byte;

        if (r_in_sysex) begin
            if (i_rx_byte == OP_SYSEX_END) begin
                n_in_sysex = 1'b0;
                if (r_data0 == FIRMWARE_QUERY) begin
                    w_burst.count = 3'd5;
                    w_burst.is_tx = 1'b1;
                    w_burst.tx[0] = OP_SYSEX_START;
                    w_burst.tx[1] = FIRMWARE_QUERY;
                    w_burst.tx[2] = {1'b0, i_cfg.fw_major};
                    w_burst.tx[3] = {1'b0, i_cfg.fw_minor};
                    w_burst.tx[4] = OP_SYSEX_END;
                end
            end else if (r_sysex_count < BUF_LIMIT) begin
                // only the first two payload bytes are kept
                if (r_sysex_count == 7'd0) begin
                    n_data0 = i_rx_byte;
                end
                if (r_sysex_count == 7'd1) begin
                    n_data1 = i_rx_byte;
                end
                n_sysex_count = r_sysex_count + 7'd1;
            end
        end else if (r_bytes_pending != 2'd0 && !i_rx_byte[7]) begin
            n_bytes_pending = r_bytes_pending - 2'd1;
            if (n_bytes_pending[0]) begin
                n_data1 = i_rx_byte;
            end else begin
                n_data0 = i_rx_byte;
            end
            if (n_bytes_pending == 2'd0 && r_pending_cmd != PC_NONE) begin
                n_pending_cmd = PC_NONE;
                w_burst.event_code = r_pending_cmd - 3'd1;
                case (r_pending_cmd)
                    PC_ANALOG, PC_DIGITAL: begin
                        w_burst.count   = 3'd1;
                        w_burst.channel = {3'b000, r_channel_latch};
                        w_burst.value   = {i_rx_byte[6:0], 7'b0} + 14'(r_data1);
                    end
                    PC_PIN_MODE, PC_PIN_VALUE: begin
                        w_burst.count   = 3'd1;
                        w_burst.channel = r_data1[6:0];
                        w_burst.value   = 14'(i_rx_byte);
                    end
                    PC_REPORT_ANALOG, PC_REPORT_DIGITAL: begin
                        w_burst.count   = 3'd1;
                        w_burst.channel = {3'b000, r_channel_latch};
                        w_burst.value   = 14'(i_rx_byte);
                    end
                    default: begin
                        w_burst.event_code = EV_ANALOG;
                    end
                endcase
            end
        end else begin
            if (i_rx_byte < OP_SYSEX_START) begin
                w_op            = {i_rx_byte[7:4], 4'h0};
                n_channel_latch = i_rx_byte[3:0];
            end
            case (w_op)
                OP_ANALOG: begin
                    n_bytes_pending = 2'd2;
                    n_pending_cmd   = PC_ANALOG;
                end
                OP_DIGITAL: begin
                    n_bytes_pending = 2'd2;
                    n_pending_cmd   = PC_DIGITAL;
                end
                OP_PIN_MODE: begin
                    n_bytes_pending = 2'd2;
                    n_pending_cmd   = PC_PIN_MODE;
                end
                OP_PIN_VALUE: begin
                    n_bytes_pending = 2'd2;
                    n_pending_cmd   = PC_PIN_VALUE;
                end
                OP_REPORT_ANALOG: begin
                    n_bytes_pending = 2'd1;
                    n_pending_cmd   = PC_REPORT_ANALOG;
                end
                OP_REPORT_DIGITAL: begin
                    n_bytes_pending = 2'd1;
                    n_pending_cmd   = PC_REPORT_DIGITAL;
                end
                OP_SYSEX_START: begin
                    n_in_sysex    = 1'b1;
                    n_sysex_count = 7'd0;
                end
                OP_RESET: begin
                    n_in_sysex      = 1'b0;
                    n_sysex_count   = 7'd0;
                    n_bytes_pending = 2'd0;
                    n_pending_cmd   = PC_NONE;
                    n_channel_latch = 4'h0;
                    n_data0         = 8'h00;
                    n_data1         = 8'h00;
                end
                OP_VERSION: begin
                    w_burst.count = 3'd3;
                    w_burst.is_tx = 1'b1;
                    w_burst.tx[0] = OP_VERSION;
                    w_burst.tx[1] = {1'b0, i_cfg.pr_major};
                    w_burst.tx[2] = {1'b0, i_cfg.pr_minor};
                end
                default: begin
                    n_pending_cmd = n_pending_cmd;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sysex      <= 1'b0;
            r_sysex_count   <= 7'd0;
            r_bytes_pending <= 2'd0;
            r_pending_cmd   <= PC_NONE;
            r_channel_latch <= 4'h0;
            r_data0         <= 8'h00;
            r_data1         <= 8'h00;
        end else if (i_fire) begin
            r_in_sysex      <= n_in_sysex;
            r_sysex_count   <= n_sysex_count;
            r_bytes_pending <= n_bytes_pending;
            r_pending_cmd   <= n_pending_cmd;
            r_channel_latch <= n_channel_latch;
            r_data0         <= n_data0;
            r_data1         <= n_data1;
        end
    end

    assign o_burst = w_burst;

    // a data wait always has a command behind it
    a_wait_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_pending != 2'd0 |-> r_pending_cmd != PC_NONE)
        else $error("data wait without pending command");

    // payload count never passes the buffer size
    a_sysex_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sysex_count <= BUF_LIMIT)
        else $error("sysex count beyond buffer size");

endmodule

@@ sv/msc_tx_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_tx_seq
// Burst register and beat sequencer driving the result channel.
// ----------------------------------------------------------------------------
module msc_tx_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  msc_pkg::t_burst      i_burst,
    input  logic                 i_stall,
    output msc_pkg::t_seq_status o_status,
    output logic                 o_valid,
    output logic                 o_out_kind,
    output logic [2:0]           o_event_code,
    output logic [6:0]           o_channel,
    output logic [13:0]          o_value,
    output logic [7:0]           o_tx_byte,
    output logic                 o_last
);
    import msc_pkg::*;

    logic       r_valid, n_valid;
    logic [2:0] r_idx,   n_idx;
    t_burst     r_burst;

    logic       w_taken;
    logic       w_last;
    logic [7:0] w_byte;

    assign w_taken = r_valid && !i_stall;
    assign w_last  = (r_idx == r_burst.count - 3'd1);

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (w_taken) begin
            if (w_last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

    always_comb begin
        case (r_idx)
            3'd0:    w_byte = r_burst.tx[0];
            3'd1:    w_byte = r_burst.tx[1];
            3'd2:    w_byte = r_burst.tx[2];
            3'd3:    w_byte = r_burst.tx[3];
            3'd4:    w_byte = r_burst.tx[4];
            default: w_byte = 8'h00;
        endcase
    end

    assign o_status.free = !r_valid || (w_taken && w_last);
    assign o_valid       = r_valid;
    assign o_out_kind    = r_burst.is_tx;
    assign o_event_code  = r_burst.event_code;
    assign o_channel     = r_burst.channel;
    assign o_value       = r_burst.value;
    assign o_tx_byte     = w_byte;
    assign o_last        = w_last;

    // a loaded burst always holds between one and five beats, index inside it
    a_idx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx < r_burst.count && r_burst.count <= 3'd5))
        else $error("beat index outside burst");

    // a decoded event is always a single beat
    a_event_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_burst.is_tx) |-> (r_burst.count == 3'd1 && r_idx == 3'd0))
        else $error("event burst longer than one beat");

    // a new burst is only loaded when the register is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_status.free)
        else $error("burst overwritten before drained");

endmodule

@@ sv/midi_style_command_parser_core.sv @@
`timescale 1ns / 1ps
// datapath: a taken byte sits in the input register, is decoded there and is loaded into
//   the burst register, which presents its first result beat on o_valid
// throughput: one byte per cycle while each byte gives at most one beat and o_valid is not
//   stalled; a reply burst (3 bytes for version, 5 for firmware report) holds the input at
//   the next byte with a result until the single burst register at the result port drains
// reset: synchronous active low; clears parser state and sets the version registers
//   to firmware 2.5 and protocol 2.5
// ----------------------------------------------------------------------------
// midi_style_command_parser_core
// Serial command parser: decodes opcodes and data bytes into events or replies.
// ----------------------------------------------------------------------------
module midi_style_command_parser_core #(
    parameter int unsigned BUFFER_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received byte beats
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // result beats
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_out_kind,
    output logic [2:0]  o_event_code,
    output logic [6:0]  o_channel,
    output logic [13:0] o_value,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    // version register writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import msc_pkg::*;

    // register indexes of the write port
    localparam logic [1:0] REG_FW_MAJOR = 2'd0;
    localparam logic [1:0] REG_FW_MINOR = 2'd1;
    localparam logic [1:0] REG_PR_MAJOR = 2'd2;
    localparam logic [1:0] REG_PR_MINOR = 2'd3;

    t_cfg        r_cfg;

    // input register
    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;

    t_burst      w_burst;
    t_seq_status w_seq;
    logic        w_consume;
    logic        w_take_in;

    // a byte with no result needs no room in the burst register
    assign w_consume = r_in_valid && ((w_burst.count == 3'd0) || w_seq.free);
    assign w_take_in = !r_in_valid || w_consume;
    assign o_stall   = !w_take_in;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_take_in) begin
            n_in_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_in && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // version registers, the user must write them only while idle; the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fw_major <= 7'd2;
            r_cfg.fw_minor <= 7'd5;
            r_cfg.pr_major <= 7'd2;
            r_cfg.pr_minor <= 7'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FW_MAJOR: r_cfg.fw_major <= i_cfg_data;
                REG_FW_MINOR: r_cfg.fw_minor <= i_cfg_data;
                REG_PR_MAJOR: r_cfg.pr_major <= i_cfg_data;
                REG_PR_MINOR: r_cfg.pr_minor <= i_cfg_data;
                default:      r_cfg.pr_minor <= r_cfg.pr_minor;
            endcase
        end
    end

    // decode of the held byte and parser state update
    msc_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_consume),
        .i_rx_byte (r_in_byte),
        .i_cfg     (r_cfg),
        .o_burst   (w_burst)
    );

    // result bursts go out one beat per cycle while the receiver does not stall
    msc_tx_seq u_tx_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_consume && (w_burst.count != 3'd0)),
        .i_burst      (w_burst),
        .i_stall      (i_stall),
        .o_status     (w_seq),
        .o_valid      (o_valid),
        .o_out_kind   (o_out_kind),
        .o_event_code (o_event_code),
        .o_channel    (o_channel),
        .o_value      (o_value),
        .o_tx_byte    (o_tx_byte),
        .o_last       (o_last)
    );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial command parser. Received bytes are driven
// beat by beat and a cycle-free software decoder of the same protocol predicts
// every event and reply byte, which is compared field by field at the output.
// ----------------------------------------------------------------------------
module tb_top;

    import msc_pkg::*;

    localparam int unsigned SYSEX_DEPTH   = 64;
    localparam int unsigned SETTLE_CYCLES = 10;    // margin for the port-to-port delay plus a full burst
    localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no beat on either side

    // version register indexes
    localparam logic [1:0] REG_FW_MAJOR = 2'd0;
    localparam logic [1:0] REG_FW_MINOR = 2'd1;
    localparam logic [1:0] REG_PR_MAJOR = 2'd2;
    localparam logic [1:0] REG_PR_MINOR = 2'd3;

    // kind of result beat
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_TX    = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [2:0]  code;
        logic [6:0]  chan;
        logic [13:0] value;
        logic [7:0]  tx;
        logic        last;
    } t_beat;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic        o_out_kind;
    logic [2:0]  o_event_code;
    logic [6:0]  o_channel;
    logic [13:0] o_value;
    logic [7:0]  o_tx_byte;
    logic        o_last;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [6:0]  i_cfg_data  = 7'd0;

    midi_style_command_parser_core #(
        .BUFFER_BYTES (SYSEX_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_kind   (o_out_kind),
        .o_event_code (o_event_code),
        .o_channel    (o_channel),
        .o_value      (o_value),
        .o_tx_byte    (o_tx_byte),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // decoder model state, mirrors the parser after every accepted byte
    // ------------------------------------------------------------------------
    t_cfg        ver_regs;
    logic        sx_active;
    int unsigned sx_count;
    logic [1:0]  wait_left;
    logic [2:0]  wait_cmd;
    logic [3:0]  chan_latch;
    logic [7:0]  data_held [2];

    t_beat       parsed_q [$];     // events and reply bytes still to come out
    int unsigned mismatch_cnt = 0;
    int unsigned sent_cnt     = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    function automatic void clear_parser();
        sx_active    = 1'b0;
        sx_count     = 0;
        wait_left    = 2'd0;
        wait_cmd     = PC_NONE;
        chan_latch   = 4'h0;
        data_held[0] = 8'h00;
        data_held[1] = 8'h00;
    endfunction

    function automatic t_beat tx_beat(input logic [7:0] b);
        t_beat r;
        r = '0;
        r.kind = KIND_TX;
        r.tx   = b;
        return r;
    endfunction

    function automatic t_beat event_beat(input logic [2:0] code, input logic [6:0] chan,
                                         input logic [13:0] value);
        t_beat r;
        r = '0;
        r.kind  = KIND_EVENT;
        r.code  = code;
        r.chan  = chan;
        r.value = value;
        return r;
    endfunction

    // decode one received byte and queue whatever it gives
    function automatic void parse_byte(input logic [7:0] b);
        t_beat      burst [$];
        t_beat      bt;
        logic [7:0] op;
        logic [15:0] word;
        if (sx_active) begin
            if (b == OP_SYSEX_END) begin
                sx_active = 1'b0;
                // an empty sysex reuses whatever the first slot still holds
                if (data_held[0] == FIRMWARE_QUERY) begin
                    burst.push_back(tx_beat(OP_SYSEX_START));
                    burst.push_back(tx_beat(FIRMWARE_QUERY));
                    burst.push_back(tx_beat({1'b0, ver_regs.fw_major}));
                    burst.push_back(tx_beat({1'b0, ver_regs.fw_minor}));
                    burst.push_back(tx_beat(OP_SYSEX_END));
                end
            end else if (sx_count < SYSEX_DEPTH) begin
                if (sx_count < 2) data_held[sx_count] = b;
                sx_count++;
            end
        end else if (wait_left != 2'd0 && !b[7]) begin
            wait_left--;
            data_held[wait_left[0]] = b;
            if (wait_left == 2'd0 && wait_cmd != PC_NONE) begin
                // first data byte sits in slot 1, second in slot 0
                word = {1'b0, data_held[0], 7'b0} + {8'h00, data_held[1]};
                case (wait_cmd)
                    PC_ANALOG:
                        burst.push_back(event_beat(EV_ANALOG, {3'b0, chan_latch}, word[13:0]));
                    PC_DIGITAL:
                        burst.push_back(event_beat(EV_DIGITAL, {3'b0, chan_latch}, word[13:0]));
                    PC_PIN_MODE:
                        burst.push_back(event_beat(EV_PIN_MODE, data_held[1][6:0],
                                                   {6'b0, data_held[0]}));
                    PC_PIN_VALUE:
                        burst.push_back(event_beat(EV_PIN_VALUE, data_held[1][6:0],
                                                   {6'b0, data_held[0]}));
                    PC_REPORT_ANALOG:
                        burst.push_back(event_beat(EV_REPORT_ANALOG, {3'b0, chan_latch},
                                                   {6'b0, data_held[0]}));
                    PC_REPORT_DIGITAL:
                        burst.push_back(event_beat(EV_REPORT_DIGITAL, {3'b0, chan_latch},
                                                   {6'b0, data_held[0]}));
                    default: ;
                endcase
                wait_cmd = PC_NONE;
            end
        end else begin
            op = b;
            // everything below the fixed opcodes updates the channel, stray data too
            if (b < OP_SYSEX_START) begin
                op         = b & 8'hF0;
                chan_latch = b[3:0];
            end
            case (op)
                OP_ANALOG:         begin wait_left = 2'd2; wait_cmd = PC_ANALOG; end
                OP_DIGITAL:        begin wait_left = 2'd2; wait_cmd = PC_DIGITAL; end
                OP_PIN_MODE:       begin wait_left = 2'd2; wait_cmd = PC_PIN_MODE; end
                OP_PIN_VALUE:      begin wait_left = 2'd2; wait_cmd = PC_PIN_VALUE; end
                OP_REPORT_ANALOG:  begin wait_left = 2'd1; wait_cmd = PC_REPORT_ANALOG; end
                OP_REPORT_DIGITAL: begin wait_left = 2'd1; wait_cmd = PC_REPORT_DIGITAL; end
                OP_SYSEX_START:    begin sx_active = 1'b1; sx_count = 0; end
                OP_RESET:          clear_parser();
                OP_VERSION: begin
                    burst.push_back(tx_beat(OP_VERSION));
                    burst.push_back(tx_beat({1'b0, ver_regs.pr_major}));
                    burst.push_back(tx_beat({1'b0, ver_regs.pr_minor}));
                end
                default: ;
            endcase
        end
        if (burst.size() != 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[k]) begin
            bt = burst[k];
            parsed_q.push_back(bt);
        end
    endfunction

    // one beat as text for the mismatch report
    function automatic string beat_str(input t_beat b);
        return $sformatf("kind=%0d code=%0d ch=%0d val=%0d tx=%02h last=%0d",
                         b.kind, b.code, b.chan, b.value, b.tx, b.last);
    endfunction

    // ------------------------------------------------------------------------
    // byte source, receiver back-pressure, output check, watchdog
    // ------------------------------------------------------------------------

    // one received byte: optional gap, then hold until taken
    task automatic push_rx_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_rx_byte = b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_byte(b);
        sent_cnt++;
    endtask

    // stop sending and let every queued beat drain, then let the burst register settle
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (parsed_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register write, only called with the parser drained
    task automatic write_version_reg(input logic [1:0] idx, input logic [6:0] v);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_FW_MAJOR: ver_regs.fw_major = v;
            REG_FW_MINOR: ver_regs.fw_minor = v;
            REG_PR_MAJOR: ver_regs.pr_major = v;
            default:      ver_regs.pr_minor = v;
        endcase
    endtask

    task automatic write_all_regs(input logic [6:0] fw_maj, input logic [6:0] fw_min,
                                  input logic [6:0] pr_maj, input logic [6:0] pr_min);
        drain_results();
        write_version_reg(REG_FW_MAJOR, fw_maj);
        write_version_reg(REG_FW_MINOR, fw_min);
        write_version_reg(REG_PR_MAJOR, pr_maj);
        write_version_reg(REG_PR_MINOR, pr_min);
    endtask

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_beats
        t_beat want;
        t_beat got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_kind, o_event_code, o_channel, o_value, o_tx_byte, o_last};
            if (parsed_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected beat %s", $realtime, beat_str(got));
            end else begin
                want = parsed_q.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: mismatch want %s, got %s",
                                 $realtime, beat_str(want), beat_str(got));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // data byte leaning towards the ends of the range
    function automatic logic [7:0] rand_data();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return 8'($urandom_range(127));
        endcase
    endfunction

    // any byte that is not the sysex terminator
    function automatic logic [7:0] rand_payload();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == OP_SYSEX_END);
        return b;
    endfunction

    // status byte that the parser does not know
    function automatic logic [7:0] rand_unknown_status();
        logic [7:0] b;
        logic       known;
        do begin
            b     = 8'($urandom_range(255, 128));
            known = (b & 8'hF0) == OP_ANALOG || (b & 8'hF0) == OP_DIGITAL ||
                    (b & 8'hF0) == OP_REPORT_ANALOG || (b & 8'hF0) == OP_REPORT_DIGITAL ||
                    b == OP_SYSEX_START || b == OP_PIN_MODE || b == OP_PIN_VALUE ||
                    b == OP_VERSION || b == OP_RESET;
        end while (known);
        return b;
    endfunction

    // opcode that opens a data wait, channel opcodes with a random channel
    function automatic logic [7:0] rand_wait_opcode();
        logic [7:0] ch;
        ch = 8'($urandom_range(15));
        case ($urandom_range(5))
            0:       return OP_ANALOG | ch;
            1:       return OP_DIGITAL | ch;
            2:       return OP_REPORT_ANALOG | ch;
            3:       return OP_REPORT_DIGITAL | ch;
            4:       return OP_PIN_MODE;
            default: return OP_PIN_VALUE;
        endcase
    endfunction

    task automatic send_wait_command();
        logic [7:0] op;
        op = rand_wait_opcode();
        push_rx_byte(op);
        push_rx_byte(rand_data());
        if ((op & 8'hF0) != OP_REPORT_ANALOG && (op & 8'hF0) != OP_REPORT_DIGITAL)
            push_rx_byte(rand_data());
    endtask

    task automatic send_sysex(input logic query, input int unsigned len);
        push_rx_byte(OP_SYSEX_START);
        if (query) push_rx_byte(FIRMWARE_QUERY);
        repeat (len) push_rx_byte(rand_payload());
        push_rx_byte(OP_SYSEX_END);
    endtask

    // a wait interrupted by a status byte or a sysex, then fed further data
    task automatic send_broken_command();
        push_rx_byte(rand_wait_opcode());
        if ($urandom_range(1)) push_rx_byte(rand_data());
        case ($urandom_range(4))
            0: push_rx_byte(rand_unknown_status());
            1: push_rx_byte(rand_wait_opcode());
            2: push_rx_byte(OP_VERSION);
            3: send_sysex(1'b0, $urandom_range(3));
            default: push_rx_byte(OP_RESET);
        endcase
        repeat ($urandom_range(2)) push_rx_byte(rand_data());
    endtask

    task automatic send_random_sequence();
        logic [7:0] b;
        case ($urandom_range(15))
            0, 1, 2, 3, 4, 5: send_wait_command();
            6:      push_rx_byte(OP_VERSION);
            7:      send_sysex(1'b1, $urandom_range(3));
            8:      send_sysex(1'b0, $urandom_range(4));
            9, 10:  send_broken_command();
            11:     push_rx_byte(rand_unknown_status());
            12:     push_rx_byte(($urandom_range(3) == 0) ? OP_RESET : rand_data());
            default: begin
                // line noise, never an unterminated sysex
                b = 8'($urandom_range(255));
                if (b == OP_SYSEX_START) b = OP_SYSEX_END;
                push_rx_byte(b);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // each opcode but reset, field extremes, default version registers
    task automatic test_opcodes();
        push_rx_byte(OP_VERSION);
        send_sysex(1'b1, 0);
        send_sysex(1'b0, 0);                     // empty sysex, first slot still 79
        push_rx_byte(OP_ANALOG | 8'h0F);
        push_rx_byte(8'h7F);
        push_rx_byte(8'h7F);
        push_rx_byte(OP_DIGITAL);
        push_rx_byte(8'h00);
        push_rx_byte(8'h00);
        push_rx_byte(OP_PIN_MODE);
        push_rx_byte(8'h0D);
        push_rx_byte(8'h01);
        push_rx_byte(OP_PIN_VALUE);
        push_rx_byte(8'h7F);
        push_rx_byte(8'h00);
        push_rx_byte(OP_REPORT_ANALOG | 8'h05);
        push_rx_byte(8'h7F);
        push_rx_byte(OP_REPORT_DIGITAL | 8'h0A);
        push_rx_byte(8'h00);
    endtask

    task automatic test_special_cases();
        // a status byte that opens a new wait replaces the old one
        push_rx_byte(OP_ANALOG | 8'h01);
        push_rx_byte(8'h05);
        push_rx_byte(OP_REPORT_ANALOG | 8'h07);
        push_rx_byte(8'h7F);
        // an unknown status keeps the wait but still moves the channel
        push_rx_byte(OP_REPORT_DIGITAL | 8'h02);
        push_rx_byte(8'hB9);
        push_rx_byte(8'h10);
        // stale sysex bytes left in the data slots, the one in slot 1 unmasked in the event
        push_rx_byte(OP_ANALOG);
        push_rx_byte(8'h11);
        push_rx_byte(OP_SYSEX_START);
        push_rx_byte(8'hE5);
        push_rx_byte(8'h81);
        push_rx_byte(OP_SYSEX_END);
        push_rx_byte(8'h22);
        // reset in the middle of a wait, then a stray data byte
        push_rx_byte(OP_DIGITAL | 8'h03);
        push_rx_byte(8'h01);
        push_rx_byte(OP_RESET);
        push_rx_byte(8'h3A);
    endtask

    // version replies at both ends of the register range
    task automatic test_version_registers();
        write_all_regs(7'h7F, 7'h7F, 7'h7F, 7'h7F);
        push_rx_byte(OP_VERSION);
        send_sysex(1'b1, 1);
        write_all_regs(7'h00, 7'h00, 7'h00, 7'h00);
        push_rx_byte(OP_VERSION);
        send_sysex(1'b1, 2);
    endtask

    // payload past the buffer size, count must saturate and the query still answer
    task automatic test_long_sysex();
        send_sysex(1'b1, SYSEX_DEPTH + 6);
        send_sysex(1'b0, 0);
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned n_items);
        int unsigned stop_at;
        write_all_regs(7'($urandom_range(127)), 7'($urandom_range(127)),
                       7'($urandom_range(127)), 7'($urandom_range(127)));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = sent_cnt + n_items;
        while (sent_cnt < stop_at) send_random_sequence();
    endtask

    initial begin
        ver_regs = '{fw_major: 7'd2, fw_minor: 7'd5, pr_major: 7'd2, pr_minor: 7'd5};
        clear_parser();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 83;
        test_opcodes();
        test_special_cases();
        test_version_registers();
        test_long_sysex();
        test_random_traffic(15, 83, 34);
        test_random_traffic(83, 15, 34);
        test_random_traffic(0, 0, 34);

        drain_results();
        if (mismatch_cnt == 0 && parsed_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
